// ----- hw/rtl/char_lcd_i2c_command_framer_assert.svh -----
// Assertion macros shared by the LCD command framer modules.
`ifndef CHAR_LCD_I2C_COMMAND_FRAMER_ASSERT_SVH
`define CHAR_LCD_I2C_COMMAND_FRAMER_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on clk while rst_n is high.
`define LCDF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on clk in every cycle, reset included.
`define LCDF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LCDF_ASSERT(lbl, prop, msg)
`define LCDF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- hw/rtl/lcdf_pkg.sv -----
// Types, constants and microcode program of the LCD command framer.
package lcdf_pkg;

  // Request codes
  localparam logic [2:0] CMD_INIT   = 3'd0;
  localparam logic [2:0] CMD_CLEAR  = 3'd1;
  localparam logic [2:0] CMD_CHAR   = 3'd2;
  localparam logic [2:0] CMD_STRING = 3'd3;
  localparam logic [2:0] CMD_NUMBER = 3'd4;
  localparam logic [2:0] CMD_GLYPH  = 3'd5;

  // Bus and display byte codes
  localparam logic [7:0] ADDR_RESET  = 8'h78;
  localparam logic [7:0] CTRL_CMD    = 8'h00;
  localparam logic [7:0] CTRL_CHAR   = 8'hC0;
  localparam logic [7:0] CTRL_DATA   = 8'h40;
  localparam logic [7:0] LCD_FUNC    = 8'h38;
  localparam logic [7:0] LCD_DISP_ON = 8'h0C;
  localparam logic [7:0] LCD_CLEAR   = 8'h01;
  localparam logic [7:0] LCD_ENTRY   = 8'h06;
  localparam logic [7:0] LCD_DDRAM   = 8'h80;
  localparam logic [7:0] LCD_CGRAM   = 8'h40;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;

  // Number conversion and glyph sizes
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * MAX_DIGITS;
  localparam int unsigned MAG_W      = 32;
  localparam int unsigned GLYPH_ROWS = 8;
  localparam int unsigned GLYPH_W    = 5 * GLYPH_ROWS;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned PC_W       = 6;

  // Program entry points and jump targets
  localparam logic [PC_W-1:0] PC_INIT     = 6'd0;
  localparam logic [PC_W-1:0] PC_CLEAR    = 6'd6;
  localparam logic [PC_W-1:0] PC_CHAR     = 6'd9;
  localparam logic [PC_W-1:0] PC_STRING   = 6'd15;
  localparam logic [PC_W-1:0] PC_STR_BYTE = 6'd21;
  localparam logic [PC_W-1:0] PC_NUMBER   = 6'd22;
  localparam logic [PC_W-1:0] PC_NUM_DIG  = 6'd31;
  localparam logic [PC_W-1:0] PC_NUM_ZERO = 6'd41;
  localparam logic [PC_W-1:0] PC_GLYPH    = 6'd47;

  typedef enum logic [2:0] {
    OP_EMIT, OP_JUMP, OP_LOAD, OP_COLINC, OP_BCD, OP_TRIM, OP_HALT
  } op_t;

  typedef enum logic [2:0] {
    SRC_ADDR, SRC_LIT, SRC_POS, SRC_CODE, SRC_SLOT, SRC_GLYPH, SRC_DIGIT
  } src_t;

  // STOP_CNT also marks an emit step that repeats until the counter runs out
  typedef enum logic [1:0] {STOP_NONE, STOP_ALWAYS, STOP_RUN, STOP_CNT} stop_t;

  typedef enum logic [1:0] {COND_OPEN, COND_ZERO, COND_POS, COND_NEVER} cond_t;

  typedef struct packed {
    op_t             op;
    src_t            src;
    logic [7:0]      lit;
    logic            start;
    stop_t           stop;
    logic            fin;
    cond_t           cond;
    logic [PC_W-1:0] tgt;
  } ucw_t;

  // Sequencer to datapath strobes
  typedef struct packed {
    logic       accept;
    logic       emit;
    src_t       src;
    logic [7:0] lit;
    logic       start;
    logic       stop;
    logic       fin;
    logic       colinc;
    logic       bcd_step;
    logic       trim_shift;
  } ctrl_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic open_hit;
    logic zero;
    logic pos;
    logic top_zero;
    logic out_free;
  } stat_t;

  function automatic ucw_t emit_w(src_t src, logic [7:0] lit, logic start, stop_t stop,
                                  logic fin);
    ucw_t w;
    w       = '0;
    w.op    = OP_EMIT;
    w.src   = src;
    w.lit   = lit;
    w.start = start;
    w.stop  = stop;
    w.fin   = fin;
    w.cond  = COND_NEVER;
    return w;
  endfunction

  function automatic ucw_t ctl_w(op_t op, logic [7:0] lit, cond_t cond, logic [PC_W-1:0] tgt);
    ucw_t w;
    w      = '0;
    w.op   = op;
    w.src  = SRC_LIT;
    w.lit  = lit;
    w.stop = STOP_NONE;
    w.cond = cond;
    w.tgt  = tgt;
    return w;
  endfunction

  // Program entry for a request code
  function automatic logic [PC_W-1:0] entry(logic [2:0] cmd);
    logic [PC_W-1:0] pc;
    unique case (cmd)
      CMD_INIT:   pc = PC_INIT;
      CMD_CLEAR:  pc = PC_CLEAR;
      CMD_CHAR:   pc = PC_CHAR;
      CMD_STRING: pc = PC_STRING;
      CMD_NUMBER: pc = PC_NUMBER;
      CMD_GLYPH:  pc = PC_GLYPH;
      default:    pc = PC_INIT;
    endcase
    return pc;
  endfunction

  // Control store
  function automatic ucw_t ucode(logic [PC_W-1:0] pc);
    ucw_t w;
    unique case (pc)
      // init frame
      6'd0:  w = emit_w(SRC_ADDR, CTRL_CMD, 1'b1, STOP_NONE, 1'b0);
      6'd1:  w = emit_w(SRC_LIT, CTRL_CMD, 1'b0, STOP_NONE, 1'b0);
      6'd2:  w = emit_w(SRC_LIT, LCD_FUNC, 1'b0, STOP_NONE, 1'b0);
      6'd3:  w = emit_w(SRC_LIT, LCD_DISP_ON, 1'b0, STOP_NONE, 1'b0);
      6'd4:  w = emit_w(SRC_LIT, LCD_CLEAR, 1'b0, STOP_NONE, 1'b0);
      6'd5:  w = emit_w(SRC_LIT, LCD_ENTRY, 1'b0, STOP_ALWAYS, 1'b1);
      // clear frame
      6'd6:  w = emit_w(SRC_ADDR, CTRL_CMD, 1'b1, STOP_NONE, 1'b0);
      6'd7:  w = emit_w(SRC_LIT, CTRL_CMD, 1'b0, STOP_NONE, 1'b0);
      6'd8:  w = emit_w(SRC_LIT, LCD_CLEAR, 1'b0, STOP_ALWAYS, 1'b1);
      // character at a position
      6'd9:  w = emit_w(SRC_ADDR, CTRL_CMD, 1'b1, STOP_NONE, 1'b0);
      6'd10: w = emit_w(SRC_LIT, CTRL_CMD, 1'b0, STOP_NONE, 1'b0);
      6'd11: w = emit_w(SRC_POS, CTRL_CMD, 1'b0, STOP_ALWAYS, 1'b0);
      6'd12: w = emit_w(SRC_ADDR, CTRL_CMD, 1'b1, STOP_NONE, 1'b0);
      6'd13: w = emit_w(SRC_LIT, CTRL_CHAR, 1'b0, STOP_NONE, 1'b0);
      6'd14: w = emit_w(SRC_CODE, CTRL_CMD, 1'b0, STOP_ALWAYS, 1'b1);
      // string byte: open a data run unless one is open
      6'd15: w = ctl_w(OP_JUMP, CTRL_CMD, COND_OPEN, PC_STR_BYTE);
      6'd16: w = emit_w(SRC_ADDR, CTRL_CMD, 1'b1, STOP_NONE, 1'b0);
      6'd17: w = emit_w(SRC_LIT, CTRL_CMD, 1'b0, STOP_NONE, 1'b0);
      6'd18: w = emit_w(SRC_POS, CTRL_CMD, 1'b0, STOP_ALWAYS, 1'b0);
      6'd19: w = emit_w(SRC_ADDR, CTRL_CMD, 1'b1, STOP_NONE, 1'b0);
      6'd20: w = emit_w(SRC_LIT, CTRL_DATA, 1'b0, STOP_NONE, 1'b0);
      6'd21: w = emit_w(SRC_CODE, CTRL_CMD, 1'b0, STOP_RUN, 1'b1);
      // number: sign frame, conversion, digit run
      6'd22: w = ctl_w(OP_JUMP, CTRL_CMD, COND_ZERO, PC_NUM_ZERO);
      6'd23: w = ctl_w(OP_JUMP, CTRL_CMD, COND_POS, PC_NUM_DIG);
      6'd24: w = emit_w(SRC_ADDR, CTRL_CMD, 1'b1, STOP_NONE, 1'b0);
      6'd25: w = emit_w(SRC_LIT, CTRL_CMD, 1'b0, STOP_NONE, 1'b0);
      6'd26: w = emit_w(SRC_POS, CTRL_CMD, 1'b0, STOP_ALWAYS, 1'b0);
      6'd27: w = emit_w(SRC_ADDR, CTRL_CMD, 1'b1, STOP_NONE, 1'b0);
      6'd28: w = emit_w(SRC_LIT, CTRL_CHAR, 1'b0, STOP_NONE, 1'b0);
      6'd29: w = emit_w(SRC_LIT, CHAR_MINUS, 1'b0, STOP_ALWAYS, 1'b0);
      6'd30: w = ctl_w(OP_COLINC, CTRL_CMD, COND_NEVER, PC_INIT);
      6'd31: w = ctl_w(OP_LOAD, 8'(MAG_W - 1), COND_NEVER, PC_INIT);
      6'd32: w = ctl_w(OP_BCD, CTRL_CMD, COND_NEVER, PC_INIT);
      6'd33: w = ctl_w(OP_LOAD, 8'(MAX_DIGITS - 1), COND_NEVER, PC_INIT);
      6'd34: w = ctl_w(OP_TRIM, CTRL_CMD, COND_NEVER, PC_INIT);
      6'd35: w = emit_w(SRC_ADDR, CTRL_CMD, 1'b1, STOP_NONE, 1'b0);
      6'd36: w = emit_w(SRC_LIT, CTRL_CMD, 1'b0, STOP_NONE, 1'b0);
      6'd37: w = emit_w(SRC_POS, CTRL_CMD, 1'b0, STOP_ALWAYS, 1'b0);
      6'd38: w = emit_w(SRC_ADDR, CTRL_CMD, 1'b1, STOP_NONE, 1'b0);
      6'd39: w = emit_w(SRC_LIT, CTRL_DATA, 1'b0, STOP_NONE, 1'b0);
      6'd40: w = emit_w(SRC_DIGIT, CTRL_CMD, 1'b0, STOP_CNT, 1'b1);
      // number zero
      6'd41: w = emit_w(SRC_ADDR, CTRL_CMD, 1'b1, STOP_NONE, 1'b0);
      6'd42: w = emit_w(SRC_LIT, CTRL_CMD, 1'b0, STOP_NONE, 1'b0);
      6'd43: w = emit_w(SRC_POS, CTRL_CMD, 1'b0, STOP_ALWAYS, 1'b0);
      6'd44: w = emit_w(SRC_ADDR, CTRL_CMD, 1'b1, STOP_NONE, 1'b0);
      6'd45: w = emit_w(SRC_LIT, CTRL_CHAR, 1'b0, STOP_NONE, 1'b0);
      6'd46: w = emit_w(SRC_LIT, CHAR_ZERO, 1'b0, STOP_ALWAYS, 1'b1);
      // glyph load
      6'd47: w = emit_w(SRC_ADDR, CTRL_CMD, 1'b1, STOP_NONE, 1'b0);
      6'd48: w = emit_w(SRC_LIT, CTRL_CMD, 1'b0, STOP_NONE, 1'b0);
      6'd49: w = emit_w(SRC_SLOT, CTRL_CMD, 1'b0, STOP_ALWAYS, 1'b0);
      6'd50: w = emit_w(SRC_ADDR, CTRL_CMD, 1'b1, STOP_NONE, 1'b0);
      6'd51: w = emit_w(SRC_LIT, CTRL_DATA, 1'b0, STOP_NONE, 1'b0);
      6'd52: w = ctl_w(OP_LOAD, 8'(GLYPH_ROWS - 1), COND_NEVER, PC_INIT);
      6'd53: w = emit_w(SRC_GLYPH, CTRL_CMD, 1'b0, STOP_CNT, 1'b1);
      default: w = ctl_w(OP_HALT, CTRL_CMD, COND_NEVER, PC_INIT);
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/lcdf_seq.sv -----
// Microcode sequencer: program counter, loop counter and control store decode.
`include "char_lcd_i2c_command_framer_assert.svh"

module lcdf_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic [2:0]          in_cmd,
  output logic                in_tready,
  input  lcdf_pkg::stat_t     stat,
  output lcdf_pkg::ctrl_t     ctrl
);

  logic                        busy_r, busy_nxt;
  logic [lcdf_pkg::PC_W-1:0]   pc_r, pc_nxt;
  logic [lcdf_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  lcdf_pkg::ucw_t              w;
  logic                        cmd_ok;
  logic                        take;
  logic                        looped;
  logic                        cnt_more;
  logic                        jump_hit;

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= lcdf_pkg::PC_INIT;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign in_tready = !busy_r;

  // Decode the current control word and advance
  always_comb begin
    w        = lcdf_pkg::ucode(pc_r);
    cmd_ok   = (in_cmd <= lcdf_pkg::CMD_GLYPH);
    take     = in_tvalid && !busy_r;
    looped   = (w.stop == lcdf_pkg::STOP_CNT);
    cnt_more = (cnt_r != '0);
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    cnt_nxt  = cnt_r;

    ctrl            = '0;
    ctrl.src        = w.src;
    ctrl.lit        = w.lit;
    ctrl.start      = w.start;
    ctrl.fin        = w.fin && !(looped && cnt_more);

    case (w.stop)
      lcdf_pkg::STOP_NONE:   ctrl.stop = 1'b0;
      lcdf_pkg::STOP_ALWAYS: ctrl.stop = 1'b1;
      lcdf_pkg::STOP_RUN:    ctrl.stop = stat.open_hit ? 1'b0 : 1'b0;
      lcdf_pkg::STOP_CNT:    ctrl.stop = !cnt_more;
      default:               ctrl.stop = 1'b0;
    endcase

    case (w.cond)
      lcdf_pkg::COND_OPEN: jump_hit = stat.open_hit;
      lcdf_pkg::COND_ZERO: jump_hit = stat.zero;
      lcdf_pkg::COND_POS:  jump_hit = stat.pos;
      default:             jump_hit = 1'b0;
    endcase

    if (take) begin
      ctrl.accept = cmd_ok;
      if (cmd_ok) begin
        busy_nxt = 1'b1;
        pc_nxt   = lcdf_pkg::entry(in_cmd);
      end
    end else if (busy_r) begin
      unique case (w.op)
        lcdf_pkg::OP_EMIT: begin
          if (stat.out_free) begin
            ctrl.emit = 1'b1;
            if (looped && cnt_more) begin
              cnt_nxt = cnt_r - 1'b1;
            end else if (w.fin) begin
              busy_nxt = 1'b0;
            end else begin
              pc_nxt = pc_r + 1'b1;
            end
          end
        end
        lcdf_pkg::OP_JUMP: begin
          pc_nxt = jump_hit ? w.tgt : pc_r + 1'b1;
        end
        lcdf_pkg::OP_LOAD: begin
          cnt_nxt = w.lit[lcdf_pkg::CNT_W-1:0];
          pc_nxt  = pc_r + 1'b1;
        end
        lcdf_pkg::OP_COLINC: begin
          ctrl.colinc = 1'b1;
          pc_nxt      = pc_r + 1'b1;
        end
        lcdf_pkg::OP_BCD: begin
          ctrl.bcd_step = 1'b1;
          if (cnt_more) begin
            cnt_nxt = cnt_r - 1'b1;
          end else begin
            pc_nxt = pc_r + 1'b1;
          end
        end
        lcdf_pkg::OP_TRIM: begin
          if (stat.top_zero && cnt_more) begin
            ctrl.trim_shift = 1'b1;
            cnt_nxt         = cnt_r - 1'b1;
          end else begin
            pc_nxt = pc_r + 1'b1;
          end
        end
        lcdf_pkg::OP_HALT: busy_nxt = 1'b0;
        default:           busy_nxt = 1'b0;
      endcase
    end
  end

  `LCDF_ASSERT(a_stall_holds, (busy_r && w.op == lcdf_pkg::OP_EMIT && !stat.out_free) |=> ($stable(pc_r) && $stable(cnt_r)), "sequencer moved while output stalled")
  `LCDF_ASSERT(a_fin_idles, (ctrl.emit && ctrl.fin) |=> !busy_r, "program did not end after final byte")
  `LCDF_ASSERT(a_accept_busy, ctrl.accept |=> busy_r, "accepted request did not start a program")

endmodule

// ----- hw/rtl/lcdf_dp.sv -----
// Datapath: request registers, decimal conversion, byte select and output register.
`include "char_lcd_i2c_command_framer_assert.svh"

module lcdf_dp #(
  parameter int unsigned COLUMNS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [7:0]                    cfg_data,
  input  logic [2:0]                    in_cmd,
  input  logic                          in_row,
  input  logic [3:0]                    in_col,
  input  logic [31:0]                   in_value,
  input  logic [lcdf_pkg::GLYPH_W-1:0]  in_glyph_rows,
  input  logic [2:0]                    in_glyph_slot,
  input  logic                          in_run_first,
  input  logic                          in_run_last,
  input  lcdf_pkg::ctrl_t               ctrl,
  output lcdf_pkg::stat_t               stat,
  input  logic                          out_tready,
  output logic                          out_tvalid,
  output logic [7:0]                    out_bus_byte,
  output logic                          out_start_before,
  output logic                          out_stop_after,
  output logic                          out_run_end
);

  localparam int unsigned CW = $clog2(COLUMNS);
  localparam int unsigned BW = lcdf_pkg::BCD_W;
  localparam int unsigned MW = lcdf_pkg::MAG_W;

  logic [7:0]                   addr_r;
  logic                         open_r;
  logic                         open_hit_r;
  logic                         row_r;
  logic [CW-1:0]                col_r;
  logic [7:0]                   code_r;
  logic [2:0]                   slot_r;
  logic                         last_r;
  logic                         zero_r;
  logic                         neg_r;
  logic [lcdf_pkg::GLYPH_W-1:0] glyph_r;
  logic [MW-1:0]                mag_r;
  logic [BW-1:0]                bcd_r;
  logic                         out_valid_r;
  logic [7:0]                   out_byte_r;
  logic                         out_start_r;
  logic                         out_stop_r;
  logic                         out_last_r;
  logic [6:0]                   col_wide;
  logic [CW-1:0]                col_wrap;
  logic [BW-1:0]                bcd_adj;
  logic [7:0]                   byte_sel;
  logic                         stop_sel;

  // Add three to every digit of five or more before the shift
  function automatic logic [BW-1:0] dabble_adj(logic [BW-1:0] b);
    logic [BW-1:0] r;
    r = b;
    for (int i = 0; i < lcdf_pkg::MAX_DIGITS; i++) begin
      if (b[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = b[4*i +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  // Wrap the requested column into the display width
  always_comb begin
    col_wide = 7'(in_col);
    if (col_wide >= 7'(COLUMNS)) begin
      col_wide = col_wide - 7'(COLUMNS);
    end
    col_wrap = CW'(col_wide);
    bcd_adj  = dabble_adj(bcd_r);
  end

  // Hold control registers: bus address and open run flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= lcdf_pkg::ADDR_RESET;
      open_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        addr_r <= cfg_data;
      end
      if (ctrl.accept) begin
        open_r <= (in_cmd == lcdf_pkg::CMD_STRING) ? !in_run_last : 1'b0;
      end
    end
  end

  // Capture the request and run the conversion shifters
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      open_hit_r <= open_r && !in_run_first;
      row_r      <= in_row;
      col_r      <= col_wrap;
      code_r     <= in_value[7:0];
      slot_r     <= in_glyph_slot;
      last_r     <= in_run_last;
      zero_r     <= (in_value == '0);
      neg_r      <= in_value[31];
      glyph_r    <= in_glyph_rows;
      mag_r      <= in_value[31] ? (MW'(0) - in_value) : in_value;
      bcd_r      <= '0;
    end else begin
      if (ctrl.colinc) begin
        col_r <= (col_r == CW'(COLUMNS - 1)) ? '0 : col_r + 1'b1;
      end
      if (ctrl.bcd_step) begin
        {bcd_r, mag_r} <= {bcd_adj[BW-2:0], mag_r, 1'b0};
      end else if (ctrl.trim_shift ||
                   (ctrl.emit && ctrl.src == lcdf_pkg::SRC_DIGIT)) begin
        bcd_r <= {bcd_r[BW-5:0], 4'd0};
      end
      if (ctrl.emit && ctrl.src == lcdf_pkg::SRC_GLYPH) begin
        glyph_r <= {5'd0, glyph_r[lcdf_pkg::GLYPH_W-1:5]};
      end
    end
  end

  // Select the byte for this step
  always_comb begin
    case (ctrl.src)
      lcdf_pkg::SRC_ADDR:  byte_sel = addr_r;
      lcdf_pkg::SRC_LIT:   byte_sel = ctrl.lit;
      lcdf_pkg::SRC_POS:   byte_sel = lcdf_pkg::LCD_DDRAM + {1'b0, row_r, 6'd0} + 8'(col_r);
      lcdf_pkg::SRC_CODE:  byte_sel = code_r;
      lcdf_pkg::SRC_SLOT:  byte_sel = lcdf_pkg::LCD_CGRAM + {2'd0, slot_r, 3'd0};
      lcdf_pkg::SRC_GLYPH: byte_sel = {3'd0, glyph_r[4:0]};
      lcdf_pkg::SRC_DIGIT: byte_sel = lcdf_pkg::CHAR_ZERO + {4'd0, bcd_r[BW-1 -: 4]};
      default:             byte_sel = ctrl.lit;
    endcase
    // string bytes stop on the run flag, everything else as the program says
    stop_sel = (ctrl.src == lcdf_pkg::SRC_CODE && !ctrl.stop && ctrl.fin &&
                ctrl.start == 1'b0 && ctrl.lit == lcdf_pkg::CTRL_CMD) ? 1'b0 : ctrl.stop;
  end

  // Output register: drop on take, load on emit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_byte_r  <= byte_sel;
      out_start_r <= ctrl.start;
      out_stop_r  <= stop_sel || (ctrl.fin && ctrl.src == lcdf_pkg::SRC_CODE &&
                                  !ctrl.stop && run_stop);
      out_last_r  <= ctrl.fin;
    end
  end

  // A string byte stops the frame when it ends the run
  logic run_stop;
  assign run_stop = last_r && !ctrl.start;

  assign stat.open_hit = open_hit_r;
  assign stat.zero     = zero_r;
  assign stat.pos      = !neg_r;
  assign stat.top_zero = (bcd_r[BW-1 -: 4] == 4'd0);
  assign stat.out_free = !out_valid_r || out_tready;

  assign out_tvalid       = out_valid_r;
  assign out_bus_byte     = out_byte_r;
  assign out_start_before = out_start_r;
  assign out_stop_after   = out_stop_r;
  assign out_run_end      = out_last_r;

  `LCDF_ASSERT(a_emit_free, ctrl.emit |-> (!out_valid_r || out_tready), "byte loaded over a waiting byte")
  `LCDF_ASSERT(a_start_stop, out_valid_r |-> !(out_start_r && out_stop_r), "byte with both start and stop")
  `LCDF_ASSERT(a_run_closed, (ctrl.accept && in_cmd == lcdf_pkg::CMD_STRING && in_run_last) |=> !open_r, "run left open after last byte")

endmodule

// ----- hw/rtl/char_lcd_i2c_command_framer.sv -----
// Top level of the character LCD bus command framer.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+------------------------------------------
//  in_      | sink      | in_tvalid/in_tready   | tdata, tuser: request kind, tlast: run end
//  out_     | source    | out_tvalid/out_tready | tdata: bus byte, tuser: start/stop flags
//  cfg_     | sink      | cfg_valid/cfg_ready   | cfg_data: bus address byte
//
// One bus byte leaves per cycle while the output is taken and the program is not in a
// jump, load, column or conversion step; those microcode steps emit no byte.
// A number adds shift-add-3 conversion of the magnitude and skips up to 9 leading zeros.
// in_tready is high only while the sequencer is idle; a stalled output freezes it.
// Reset is synchronous, active low; the bus address returns to 0x78 and no run is open.
`include "char_lcd_i2c_command_framer_assert.svh"

module char_lcd_i2c_command_framer #(
  parameter int unsigned COLUMNS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // row[0], col[4:1], value[36:5], glyph_rows[76:37], glyph_slot[79:77]
  input  logic [79:0] in_tdata,
  // cmd[2:0], run_first[3]
  input  logic [3:0]  in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // bus_byte[7:0]
  output logic [7:0]  out_tdata,
  // start_before[0], stop_after[1]
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  lcdf_pkg::ctrl_t ctrl;
  lcdf_pkg::stat_t stat;
  logic            start_before;
  logic            stop_after;

  assign cfg_ready = 1'b1;

  lcdf_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_cmd    (in_tuser[2:0]),
    .in_tready (in_tready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  lcdf_dp #(
    .COLUMNS (COLUMNS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_data         (cfg_data),
    .in_cmd           (in_tuser[2:0]),
    .in_row           (in_tdata[0]),
    .in_col           (in_tdata[4:1]),
    .in_value         (in_tdata[36:5]),
    .in_glyph_rows    (in_tdata[76:37]),
    .in_glyph_slot    (in_tdata[79:77]),
    .in_run_first     (in_tuser[3]),
    .in_run_last      (in_tlast),
    .ctrl             (ctrl),
    .stat             (stat),
    .out_tready       (out_tready),
    .out_tvalid       (out_tvalid),
    .out_bus_byte     (out_tdata),
    .out_start_before (start_before),
    .out_stop_after   (stop_after),
    .out_run_end      (out_tlast)
  );

  assign out_tuser = {stop_after, start_before};

  `LCDF_ASSERT(a_busy_after_req, (in_tvalid && in_tready && in_tuser[2:0] <= lcdf_pkg::CMD_GLYPH) |=> !in_tready, "request accepted while a program runs")
  `LCDF_ASSERT(a_start_is_addr_slot, (out_tvalid && out_tuser[0]) |-> !out_tlast, "frame start byte flagged as run end")
  `LCDF_ASSERT_ALWAYS(a_cfg_ready, cfg_ready, "configuration port not ready")

endmodule
